[rtl/teq_pkg.sv]
// ============================================================================
// teq_pkg
// Shared types and constants for the timed event queue.
// ============================================================================
`default_nettype none

package teq_pkg;

  localparam int unsigned TypeW  = 4;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DelayW = 31;
  localparam int unsigned StepW  = 16;
  localparam int unsigned EntryW = TypeW + TimeW;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CHANGE = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_TICK   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_DT,
    ST_RM_RD,
    ST_RM_DT,
    ST_TK_RD,
    ST_TK_DT,
    ST_TK_END,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

[rtl/teq_mem.sv]
// ============================================================================
// teq_mem
// Single-port-write, single-port-read entry memory, registered read data.
// ============================================================================
`default_nettype none

module teq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [AW-1:0]                waddr_i,
  input  wire logic [teq_pkg::EntryW-1:0]   wdata_i,
  input  wire logic                         re_i,
  input  wire logic [AW-1:0]                raddr_i,
  output logic      [teq_pkg::EntryW-1:0]   rdata_o
);

  logic [teq_pkg::EntryW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/timed_event_queue_top.sv]
// ============================================================================
// timed_event_queue_top
// Sorted queue of timed events held in one entry memory.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one word per operation:
// add, change time, remove or tick. Output channel (out_valid_o /
// out_stall_i) returns one word per add, change or remove, and one word
// per expired event on a tick (or a single empty word), last set on the
// final word of each operation.
// Each operation walks the entry memory with a read state and a process
// state per visited entry (registered read data):
//   add     : shifts later entries up from the tail, no walk if full
//   remove  : visits every entry, closing the gap behind the match
//   change  : remove walk plus add walk
//   tick    : visits every entry, plus any output stall
// A new word is taken only when the previous operation has finished; its
// result may still sit in the output register.
// Reset empties the queue; memory contents are not cleared, entries past
// the count are never read. While out_stall_i is high the output word holds
// and a tick that has another event to report waits.
// ============================================================================
`default_nettype none

module timed_event_queue_top #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned TYPES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  in_kind_i,
  input  wire logic [3:0]  in_event_type_i,
  input  wire logic [30:0] in_delay_i,
  input  wire logic [15:0] in_elapsed_i,
  input  wire logic [15:0] in_step_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       out_status_o,
  output logic             out_fired_o,
  output logic [3:0]       out_fired_type_o,
  output logic             out_last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned TW = teq_pkg::TypeW;
  localparam int unsigned MW = teq_pkg::TimeW;
  localparam int unsigned EW = teq_pkg::EntryW;

  teq_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] k_q, k_d;
  logic          found_q, found_d;
  logic          pend_q, pend_d;
  logic [TW-1:0] pend_type_q, pend_type_d;
  logic [1:0]    status_q, status_d;

  teq_pkg::kind_e kind_q;
  logic [TW-1:0]  type_q;
  logic [MW-1:0]  time_q;
  logic [15:0]    step_q;

  logic          out_valid_q;
  logic [1:0]    out_status_q;
  logic          out_fired_q;
  logic [TW-1:0] out_type_q;
  logic          out_last_q;

  logic          emit;
  logic [1:0]    emit_status;
  logic          emit_fired;
  logic [TW-1:0] emit_type;
  logic          emit_last;

  logic          we, re;
  logic [CW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic [TW-1:0]        r_type;
  logic signed [MW-1:0] r_time;
  logic signed [MW-1:0] new_time;
  logic                 expired;
  logic                 can_load;
  logic                 accept;
  logic                 type_ok;
  logic [MW-1:0]        sum;

  assign r_type   = rdata[EW-1:MW];
  assign r_time   = $signed(rdata[MW-1:0]);
  assign new_time = r_time - $signed({16'b0, step_q});
  assign expired  = new_time[MW-1] | (new_time == '0);
  assign can_load = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && (state_q == teq_pkg::ST_IDLE);
  assign type_ok  = (32'(in_event_type_i) < TYPES);
  assign sum      = 32'(in_delay_i) + 32'(in_elapsed_i);

  assign in_stall_o = (state_q != teq_pkg::ST_IDLE);

  teq_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr[AW-1:0]),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr[AW-1:0]),
    .rdata_o(rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      teq_pkg::ST_IDLE: begin
        if (accept) begin
          if (teq_pkg::kind_e'(in_kind_i) == teq_pkg::KIND_TICK) begin
            state_d = teq_pkg::ST_TK_RD;
          end else if (!type_ok) begin
            state_d = teq_pkg::ST_RESP;
          end else if (teq_pkg::kind_e'(in_kind_i) == teq_pkg::KIND_ADD) begin
            state_d = (count_q == CW'(DEPTH)) ? teq_pkg::ST_RESP : teq_pkg::ST_ADD_RD;
          end else begin
            state_d = teq_pkg::ST_RM_RD;
          end
        end
      end
      teq_pkg::ST_ADD_RD: begin
        state_d = (pos_q == '0) ? teq_pkg::ST_RESP : teq_pkg::ST_ADD_DT;
      end
      teq_pkg::ST_ADD_DT: begin
        state_d = (r_time > $signed(time_q)) ? teq_pkg::ST_ADD_RD : teq_pkg::ST_RESP;
      end
      teq_pkg::ST_RM_RD: begin
        if (pos_q == count_q) begin
          state_d = (found_q && kind_q == teq_pkg::KIND_CHANGE) ?
                    teq_pkg::ST_ADD_RD : teq_pkg::ST_RESP;
        end else begin
          state_d = teq_pkg::ST_RM_DT;
        end
      end
      teq_pkg::ST_RM_DT: state_d = teq_pkg::ST_RM_RD;
      teq_pkg::ST_TK_RD: begin
        state_d = (pos_q == count_q) ? teq_pkg::ST_TK_END : teq_pkg::ST_TK_DT;
      end
      teq_pkg::ST_TK_DT: begin
        if (!(expired && pend_q && !can_load)) begin
          state_d = teq_pkg::ST_TK_RD;
        end
      end
      teq_pkg::ST_TK_END: if (can_load) state_d = teq_pkg::ST_IDLE;
      teq_pkg::ST_RESP:   if (can_load) state_d = teq_pkg::ST_IDLE;
      default:            state_d = teq_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d     = count_q;
    pos_d       = pos_q;
    k_d         = k_q;
    found_d     = found_q;
    pend_d      = pend_q;
    pend_type_d = pend_type_q;
    status_d    = status_q;
    emit        = 1'b0;
    emit_status = teq_pkg::STATUS_OK;
    emit_fired  = 1'b0;
    emit_type   = '0;
    emit_last   = 1'b1;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = {type_q, time_q};
    re          = 1'b0;
    raddr       = pos_q;
    unique case (state_q)
      teq_pkg::ST_IDLE: begin
        if (accept) begin
          pos_d    = '0;
          k_d      = '0;
          found_d  = 1'b0;
          pend_d   = 1'b0;
          status_d = teq_pkg::STATUS_OK;
          if (teq_pkg::kind_e'(in_kind_i) != teq_pkg::KIND_TICK) begin
            if (!type_ok) begin
              status_d = teq_pkg::STATUS_NOT_FOUND;
            end else if (teq_pkg::kind_e'(in_kind_i) == teq_pkg::KIND_ADD) begin
              if (count_q == CW'(DEPTH)) status_d = teq_pkg::STATUS_FULL;
              pos_d = count_q;
            end
          end
        end
      end
      teq_pkg::ST_ADD_RD: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          waddr   = '0;
          count_d = count_q + 1'b1;
        end else begin
          re    = 1'b1;
          raddr = pos_q - 1'b1;
        end
      end
      teq_pkg::ST_ADD_DT: begin
        we    = 1'b1;
        waddr = pos_q;
        if (r_time > $signed(time_q)) begin
          wdata = rdata;
          pos_d = pos_q - 1'b1;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      teq_pkg::ST_RM_RD: begin
        if (pos_q == count_q) begin
          if (!found_q) begin
            status_d = teq_pkg::STATUS_NOT_FOUND;
          end else begin
            count_d = count_q - 1'b1;
            pos_d   = count_q - 1'b1;
          end
        end else begin
          re = 1'b1;
        end
      end
      teq_pkg::ST_RM_DT: begin
        if (found_q) begin
          we    = 1'b1;
          waddr = pos_q - 1'b1;
          wdata = rdata;
        end else if (r_type == type_q) begin
          found_d = 1'b1;
        end
        pos_d = pos_q + 1'b1;
      end
      teq_pkg::ST_TK_RD: begin
        if (pos_q != count_q) re = 1'b1;
      end
      teq_pkg::ST_TK_DT: begin
        if (expired) begin
          if (!(pend_q && !can_load)) begin
            emit        = pend_q;
            emit_fired  = 1'b1;
            emit_type   = pend_type_q;
            emit_last   = 1'b0;
            pend_d      = 1'b1;
            pend_type_d = r_type;
            k_d         = k_q + 1'b1;
            pos_d       = pos_q + 1'b1;
          end
        end else begin
          we    = 1'b1;
          waddr = pos_q - k_q;
          wdata = {r_type, new_time};
          pos_d = pos_q + 1'b1;
        end
      end
      teq_pkg::ST_TK_END: begin
        if (can_load) begin
          emit       = 1'b1;
          emit_fired = pend_q;
          emit_type  = pend_q ? pend_type_q : '0;
          count_d    = count_q - k_q;
        end
      end
      teq_pkg::ST_RESP: begin
        if (can_load) begin
          emit        = 1'b1;
          emit_status = status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= teq_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      k_q         <= '0;
      found_q     <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      k_q     <= k_d;
      found_q <= found_d;
      pend_q  <= pend_d;
      if (can_load) out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_type_q <= pend_type_d;
    status_q    <= status_d;
    if (accept) begin
      kind_q <= teq_pkg::kind_e'(in_kind_i);
      type_q <= in_event_type_i;
      time_q <= sum[MW-1] ? {1'b0, {(MW-1){1'b1}}} : sum;
      step_q <= in_step_i;
    end
    if (can_load && emit) begin
      out_status_q <= emit_status;
      out_fired_q  <= emit_fired;
      out_type_q   <= emit_type;
      out_last_q   <= emit_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_fired_o      = out_fired_q;
  assign out_fired_type_o = out_type_q;
  assign out_last_o       = out_last_q;

endmodule

`default_nettype wire
